@@ rtl/kgr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the group reverse buffer: shared constants and the
// descriptor and bank-release types passed between front, queue and drain.
// No dependencies.
package kgr_pkg;

    localparam int KGR_MAX_GROUP = 16;
    localparam int KGR_DATA_W    = 32;
    localparam int KGR_GS_W      = 5;

    localparam logic [KGR_GS_W-1:0] KGR_GS_RESET = 5'd2;

    typedef struct packed {
        logic bank;
        logic rev;
        logic last;
    } kgr_flags_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } kgr_rel_t;

endpackage

@@ rtl/kgr_front.sv @@
`timescale 1ns / 1ps
// Front end: group size register, input acceptance, bank fill tracking
// and group classification. Depends on kgr_pkg.
module kgr_front #(
    parameter int MAX_GROUP = kgr_pkg::KGR_MAX_GROUP,
    localparam int CNT_W = $clog2(MAX_GROUP + 1),
    localparam int IDX_W = $clog2(MAX_GROUP)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [kgr_pkg::KGR_GS_W-1:0]        cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [kgr_pkg::KGR_DATA_W-1:0] value,
    input  logic                                seq_end,
    output logic                                wr_en,
    output logic [IDX_W:0]                      wr_addr,
    output logic signed [kgr_pkg::KGR_DATA_W-1:0] wr_data,
    output logic                                push,
    output kgr_pkg::kgr_flags_t                 push_flags,
    output logic [CNT_W-1:0]                    push_count,
    input  logic                                q_full,
    input  kgr_pkg::kgr_rel_t                   rel_info
);
    import kgr_pkg::*;

    localparam int CW = (CNT_W > KGR_GS_W) ? CNT_W : KGR_GS_W;

    logic [KGR_GS_W-1:0] gs_reg;
    logic [KGR_GS_W-1:0] gs_next;
    logic                bank_reg;
    logic                bank_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [1:0]          busy_reg;
    logic [1:0]          busy_next;

    logic [CW-1:0]    gs_ext;
    logic [CW-1:0]    max_ext;
    logic [CW-1:0]    k_eff;
    logic [CNT_W-1:0] fill_n;
    logic             reach;
    logic             accept;

    always_comb
    begin
        gs_ext  = CW'(gs_reg);
        max_ext = CW'(MAX_GROUP);
        if (gs_ext == '0)
        begin
            k_eff = CW'(1);
        end
        else if (gs_ext > max_ext)
        begin
            k_eff = max_ext;
        end
        else
        begin
            k_eff = gs_ext;
        end
        fill_n = fill_reg + CNT_W'(1);
        reach  = CW'(fill_n) >= k_eff;
    end

    assign in_stall = busy_reg[bank_reg] | q_full;
    assign accept   = in_valid && !in_stall;

    assign wr_en      = accept;
    assign wr_addr    = {bank_reg, fill_reg[IDX_W-1:0]};
    assign wr_data    = value;
    assign push       = accept && (reach || seq_end);
    assign push_flags = '{bank: bank_reg, rev: reach, last: seq_end};
    assign push_count = fill_n;

    always_comb
    begin
        gs_next   = gs_reg;
        bank_next = bank_reg;
        fill_next = fill_reg;
        busy_next = busy_reg;
        if (cfg_wr_en)
        begin
            gs_next = cfg_wr_data;
        end
        if (rel_info.valid)
        begin
            busy_next[rel_info.bank] = 1'b0;
        end
        if (accept)
        begin
            if (push)
            begin
                busy_next[bank_reg] = 1'b1;
                bank_next           = ~bank_reg;
                fill_next           = '0;
            end
            else
            begin
                fill_next = fill_n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg   <= KGR_GS_RESET;
            bank_reg <= 1'b0;
            fill_reg <= '0;
            busy_reg <= '0;
        end
        else
        begin
            gs_reg   <= gs_next;
            bank_reg <= bank_next;
            fill_reg <= fill_next;
            busy_reg <= busy_next;
        end
    end

endmodule

@@ rtl/kgr_queue.sv @@
`timescale 1ns / 1ps
// Two-entry descriptor queue between the front end and the drain unit.
// Depends on kgr_pkg.
module kgr_queue #(
    parameter int MAX_GROUP = kgr_pkg::KGR_MAX_GROUP,
    localparam int CNT_W = $clog2(MAX_GROUP + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  kgr_pkg::kgr_flags_t push_flags,
    input  logic [CNT_W-1:0]    push_count,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output kgr_pkg::kgr_flags_t pop_flags,
    output logic [CNT_W-1:0]    pop_count
);
    import kgr_pkg::*;

    kgr_flags_t       flags_reg [2];
    logic [CNT_W-1:0] count_reg [2];
    logic             wptr_reg;
    logic             wptr_next;
    logic             rptr_reg;
    logic             rptr_next;
    logic [1:0]       used_reg;
    logic [1:0]       used_next;

    assign full      = used_reg == 2'd2;
    assign empty     = used_reg == 2'd0;
    assign pop_flags = flags_reg[rptr_reg];
    assign pop_count = count_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        used_next = used_reg;
        if (push)
        begin
            wptr_next = ~wptr_reg;
        end
        if (pop)
        begin
            rptr_next = ~rptr_reg;
        end
        if (push && !pop)
        begin
            used_next = used_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            used_next = used_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            flags_reg[wptr_reg] <= push_flags;
            count_reg[wptr_reg] <= push_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            used_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            used_reg <= used_next;
        end
    end

endmodule

@@ rtl/kgr_drain.sv @@
`timescale 1ns / 1ps
// Drain unit: ping-pong group store and the sequencer that reads a held
// group out forward or reversed into the output register. Depends on kgr_pkg.
module kgr_drain #(
    parameter int MAX_GROUP = kgr_pkg::KGR_MAX_GROUP,
    localparam int CNT_W = $clog2(MAX_GROUP + 1),
    localparam int IDX_W = $clog2(MAX_GROUP)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [IDX_W:0]                        wr_addr,
    input  logic signed [kgr_pkg::KGR_DATA_W-1:0] wr_data,
    input  logic                                  q_empty,
    output logic                                  pop,
    input  kgr_pkg::kgr_flags_t                   q_flags,
    input  logic [CNT_W-1:0]                      q_count,
    output kgr_pkg::kgr_rel_t                     rel_info,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [kgr_pkg::KGR_DATA_W-1:0] out_value,
    output logic                                  out_end
);
    import kgr_pkg::*;

    localparam int DEPTH = 2 ** (IDX_W + 1);

    logic signed [KGR_DATA_W-1:0] mem [DEPTH];

    logic                  active_reg;
    logic                  active_next;
    logic                  bank_reg;
    logic                  bank_next;
    logic                  rev_reg;
    logic                  rev_next;
    logic                  last_reg;
    logic                  last_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [IDX_W-1:0]      pos_reg;
    logic [IDX_W-1:0]      pos_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_end_reg;
    logic                  out_end_next;
    logic signed [KGR_DATA_W-1:0] out_data_reg;

    logic             load_ok;
    logic             issue;
    logic             pos_last;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W:0]   rd_addr;

    always_comb
    begin
        load_ok  = !out_valid_reg || !out_stall;
        issue    = active_reg && load_ok;
        pos_last = CNT_W'(pos_reg) == (cnt_reg - CNT_W'(1));
        if (rev_reg)
        begin
            rd_idx = IDX_W'(cnt_reg - CNT_W'(1) - CNT_W'(pos_reg));
        end
        else
        begin
            rd_idx = pos_reg;
        end
        rd_addr = {bank_reg, rd_idx};
        pop     = !active_reg && !q_empty;
    end

    assign rel_info  = '{valid: issue && pos_last, bank: bank_reg};
    assign out_valid = out_valid_reg;
    assign out_value = out_data_reg;
    assign out_end   = out_end_reg;

    always_comb
    begin
        active_next    = active_reg;
        bank_next      = bank_reg;
        rev_next       = rev_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_end_next   = out_end_reg;
        if (pop)
        begin
            active_next = 1'b1;
            bank_next   = q_flags.bank;
            rev_next    = q_flags.rev;
            last_next   = q_flags.last;
            cnt_next    = q_count;
            pos_next    = '0;
        end
        if (load_ok)
        begin
            out_valid_next = issue;
        end
        if (issue)
        begin
            out_end_next = last_reg && pos_last;
            pos_next     = pos_reg + IDX_W'(1);
            if (pos_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            out_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            bank_reg      <= 1'b0;
            rev_reg       <= 1'b0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_end_reg   <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            bank_reg      <= bank_next;
            rev_reg       <= rev_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            out_end_reg   <= out_end_next;
        end
    end

endmodule

@@ rtl/k_group_reverse_buffer_unit.sv @@
`timescale 1ns / 1ps
// Group closing queues a descriptor; the drain pops it, then registers the group's first value.
// Throughput: one input transaction per cycle while a store bank is free; two banks, so
// input stalls only when both hold groups not yet drained. Output: one value per cycle while
// out_stall is low, from the drain read port; idle between groups while it pops a descriptor.
// Reset: asynchronous, active low; empties both banks and sets group size to 2.
// Top level of the group reverse buffer. Depends on kgr_pkg, kgr_front, kgr_queue, kgr_drain.
module k_group_reverse_buffer_unit #(
    parameter int MAX_GROUP = kgr_pkg::KGR_MAX_GROUP
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [kgr_pkg::KGR_GS_W-1:0]          cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [kgr_pkg::KGR_DATA_W-1:0] value,
    input  logic                                  seq_end,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [kgr_pkg::KGR_DATA_W-1:0] out_value,
    output logic                                  out_end
);
    import kgr_pkg::*;

    localparam int CNT_W = $clog2(MAX_GROUP + 1);
    localparam int IDX_W = $clog2(MAX_GROUP);

    logic                         wr_en;
    logic [IDX_W:0]               wr_addr;
    logic signed [KGR_DATA_W-1:0] wr_data;
    logic                         push;
    kgr_flags_t                   push_flags;
    logic [CNT_W-1:0]             push_count;
    logic                         pop;
    logic                         q_full;
    logic                         q_empty;
    kgr_flags_t                   q_flags;
    logic [CNT_W-1:0]             q_count;
    kgr_rel_t                     rel_info;

    kgr_front #(
        .MAX_GROUP (MAX_GROUP)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .seq_end     (seq_end),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .push        (push),
        .push_flags  (push_flags),
        .push_count  (push_count),
        .q_full      (q_full),
        .rel_info    (rel_info)
    );

    kgr_queue #(
        .MAX_GROUP (MAX_GROUP)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_flags (push_flags),
        .push_count (push_count),
        .pop        (pop),
        .full       (q_full),
        .empty      (q_empty),
        .pop_flags  (q_flags),
        .pop_count  (q_count)
    );

    kgr_drain #(
        .MAX_GROUP (MAX_GROUP)
    ) u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .q_empty   (q_empty),
        .pop       (pop),
        .q_flags   (q_flags),
        .q_count   (q_count),
        .rel_info  (rel_info),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (out_value),
        .out_end   (out_end)
    );

endmodule
